// ===== rtl/core/ddf_pkg.sv =====
// Shared types and constants of the address dedupe filter with pending FIFO.
`default_nettype none

package ddf_pkg;

	localparam int SEEN_DEPTH  = 64;
	localparam int QUEUE_DEPTH = 32;

	localparam int SIDX_W = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
	localparam int SCNT_W = $clog2(SEEN_DEPTH + 1);
	localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int ADDR_W  = 48;
	localparam int KIND_W  = 2;
	localparam int LEVEL_W = 8;
	localparam int TIME_W  = 32;
	localparam int MAKER_W = 16;
	localparam int DEPTH_W = 6;
	localparam int TOTAL_W = 32;

	typedef enum logic [2:0] {
		ST_QUEUED     = 3'd0,
		ST_DUP        = 3'd1,
		ST_MALFORMED  = 3'd2,
		ST_TABLE_FULL = 3'd3,
		ST_FIFO_FULL  = 3'd4,
		ST_POPPED     = 3'd5,
		ST_EMPTY      = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_COMMIT = 3'b100
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic scan_done;
		logic skip;
	} sts_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [KIND_W-1:0] kind;
	} seen_ent_t;

	typedef struct packed {
		logic [ADDR_W-1:0]         addr;
		logic [KIND_W-1:0]         kind;
		logic signed [LEVEL_W-1:0] level;
		logic [TIME_W-1:0]         tms;
		logic [MAKER_W-1:0]        maker;
	} fifo_ent_t;

endpackage

`default_nettype wire

// ===== rtl/core/ddf_ctrl.sv =====
// Controller state machine of the dedupe filter: load, table scan, commit.
`default_nettype none

module ddf_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire ddf_pkg::sts_t sts,
	output ddf_pkg::cmd_t      cmd,
	output logic               busy
);

	ddf_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ddf_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ddf_pkg::S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = ddf_pkg::S_SCAN;
				end
			end
			ddf_pkg::S_SCAN: begin
				// The scan state also reads the FIFO head, so even a pop passes through it.
				cmd.scan = 1'b1;
				if (sts.skip || sts.scan_done) begin
					state_nxt = ddf_pkg::S_COMMIT;
				end
			end
			ddf_pkg::S_COMMIT: begin
				cmd.commit = 1'b1;
				state_nxt  = ddf_pkg::S_IDLE;
			end
			default: begin
				state_nxt = ddf_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ddf_pkg::S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/ddf_datapath.sv =====
// Datapath of the dedupe filter: seen-table, pending FIFO, counters and result registers.
`default_nettype none

module ddf_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ddf_pkg::cmd_t                 cmd,
	output ddf_pkg::sts_t                      sts,
	input  wire logic                          mode,
	input  wire logic [ddf_pkg::ADDR_W-1:0]    addr_bits,
	input  wire logic                          addr_well_formed,
	input  wire logic [ddf_pkg::KIND_W-1:0]    addr_kind,
	input  wire logic signed [ddf_pkg::LEVEL_W-1:0] signal_level,
	input  wire logic [ddf_pkg::TIME_W-1:0]    seen_time_ms,
	input  wire logic [ddf_pkg::MAKER_W-1:0]   maker_id,
	output logic                               done,
	output ddf_pkg::status_t                   status,
	output logic [ddf_pkg::ADDR_W-1:0]         out_addr,
	output logic [ddf_pkg::KIND_W-1:0]         out_kind,
	output logic signed [ddf_pkg::LEVEL_W-1:0] out_level,
	output logic [ddf_pkg::TIME_W-1:0]         out_time_ms,
	output logic [ddf_pkg::MAKER_W-1:0]        out_maker,
	output logic [ddf_pkg::DEPTH_W-1:0]        queue_depth,
	output logic [ddf_pkg::TOTAL_W-1:0]        drop_total,
	output logic [ddf_pkg::TOTAL_W-1:0]        unique_total,
	output logic [ddf_pkg::TOTAL_W-1:0]        dup_total
);

	localparam int QSUM_W = ddf_pkg::QCNT_W + 1;

	ddf_pkg::seen_ent_t seen_mem [ddf_pkg::SEEN_DEPTH];
	ddf_pkg::fifo_ent_t fifo_mem [ddf_pkg::QUEUE_DEPTH];

	// Latched input word.
	logic               mode_q;
	logic               wf_q;
	ddf_pkg::fifo_ent_t ent_q;

	logic [ddf_pkg::SCNT_W-1:0] issue_q;
	logic                       cmp_vld_s1;
	ddf_pkg::seen_ent_t         seen_rd_s1;
	logic                       hit_q;
	logic [ddf_pkg::SCNT_W-1:0] seen_cnt_q;

	ddf_pkg::fifo_ent_t         fifo_rd_s1;
	logic [ddf_pkg::QIDX_W-1:0] head_q;
	logic [ddf_pkg::QCNT_W-1:0] fill_q;

	logic [ddf_pkg::TOTAL_W-1:0] drops_q, uniq_q, dups_q;

	logic                       done_q;
	ddf_pkg::status_t           status_q;
	ddf_pkg::fifo_ent_t         out_q;

	logic                       issue_more;
	logic [QSUM_W-1:0]          tail_sum;
	logic [ddf_pkg::QIDX_W-1:0] tail;
	logic [ddf_pkg::QIDX_W-1:0] head_inc;

	ddf_pkg::status_t nxt_status;
	logic             pop, seen_we, fifo_we, inc_drop, inc_uniq, inc_dup;

	assign issue_more    = (issue_q < seen_cnt_q);
	assign sts.scan_done = !issue_more && !cmp_vld_s1;
	assign sts.skip      = mode_q || !wf_q;

	always_comb begin
		tail_sum = QSUM_W'(head_q) + QSUM_W'(fill_q);
		if (tail_sum >= QSUM_W'(ddf_pkg::QUEUE_DEPTH)) begin
			tail_sum = tail_sum - QSUM_W'(ddf_pkg::QUEUE_DEPTH);
		end
		tail = tail_sum[ddf_pkg::QIDX_W-1:0];
		if (head_q == ddf_pkg::QIDX_W'(ddf_pkg::QUEUE_DEPTH - 1)) begin
			head_inc = '0;
		end else begin
			head_inc = head_q + 1'b1;
		end
	end

	// Outcome of the item, evaluated in the commit cycle.
	always_comb begin
		nxt_status = ddf_pkg::ST_EMPTY;
		pop        = 1'b0;
		seen_we    = 1'b0;
		fifo_we    = 1'b0;
		inc_drop   = 1'b0;
		inc_uniq   = 1'b0;
		inc_dup    = 1'b0;
		if (mode_q) begin
			if (fill_q != '0) begin
				pop        = 1'b1;
				nxt_status = ddf_pkg::ST_POPPED;
			end
		end else if (!wf_q) begin
			inc_drop   = 1'b1;
			nxt_status = ddf_pkg::ST_MALFORMED;
		end else if (hit_q) begin
			inc_dup    = 1'b1;
			nxt_status = ddf_pkg::ST_DUP;
		end else if (seen_cnt_q >= ddf_pkg::SCNT_W'(ddf_pkg::SEEN_DEPTH)) begin
			inc_drop   = 1'b1;
			nxt_status = ddf_pkg::ST_TABLE_FULL;
		end else begin
			seen_we  = 1'b1;
			inc_uniq = 1'b1;
			if (fill_q >= ddf_pkg::QCNT_W'(ddf_pkg::QUEUE_DEPTH)) begin
				inc_drop   = 1'b1;
				nxt_status = ddf_pkg::ST_FIFO_FULL;
			end else begin
				fifo_we    = 1'b1;
				nxt_status = ddf_pkg::ST_QUEUED;
			end
		end
	end

	// Memories.
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			seen_rd_s1 <= seen_mem[issue_q[ddf_pkg::SIDX_W-1:0]];
			fifo_rd_s1 <= fifo_mem[head_q];
		end
		if (cmd.commit && seen_we) begin
			seen_mem[seen_cnt_q[ddf_pkg::SIDX_W-1:0]] <= '{addr: ent_q.addr, kind: ent_q.kind};
		end
		if (cmd.commit && fifo_we) begin
			fifo_mem[tail] <= ent_q;
		end
	end

	// Input word and result payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q      <= mode;
			wf_q        <= addr_well_formed;
			ent_q.addr  <= addr_bits;
			ent_q.kind  <= addr_kind;
			ent_q.level <= signal_level;
			ent_q.tms   <= seen_time_ms;
			ent_q.maker <= maker_id;
		end
		if (cmd.commit) begin
			status_q <= nxt_status;
			out_q    <= pop ? fifo_rd_s1 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q    <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
			seen_cnt_q <= '0;
			head_q     <= '0;
			fill_q     <= '0;
			drops_q    <= '0;
			uniq_q     <= '0;
			dups_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q     <= cmd.commit;
			cmp_vld_s1 <= cmd.scan && issue_more;
			if (cmd.load) begin
				issue_q <= '0;
				hit_q   <= 1'b0;
			end else begin
				if (cmd.scan && issue_more) begin
					issue_q <= issue_q + 1'b1;
				end
				if (cmp_vld_s1 && seen_rd_s1.addr == ent_q.addr
						&& seen_rd_s1.kind == ent_q.kind) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				if (seen_we) begin
					seen_cnt_q <= seen_cnt_q + 1'b1;
				end
				if (pop) begin
					head_q <= head_inc;
					fill_q <= fill_q - 1'b1;
				end else if (fifo_we) begin
					fill_q <= fill_q + 1'b1;
				end
				if (inc_drop && drops_q != '1) begin
					drops_q <= drops_q + 1'b1;
				end
				if (inc_uniq && uniq_q != '1) begin
					uniq_q <= uniq_q + 1'b1;
				end
				if (inc_dup && dups_q != '1) begin
					dups_q <= dups_q + 1'b1;
				end
			end
		end
	end

	// Counters and fill change only at commit, so they read straight out as totals.
	assign done         = done_q;
	assign status       = status_q;
	assign out_addr     = out_q.addr;
	assign out_kind     = out_q.kind;
	assign out_level    = out_q.level;
	assign out_time_ms  = out_q.tms;
	assign out_maker    = out_q.maker;
	assign queue_depth  = ddf_pkg::DEPTH_W'(fill_q);
	assign drop_total   = drops_q;
	assign unique_total = uniq_q;
	assign dup_total    = dups_q;

endmodule

`default_nettype wire

// ===== rtl/core/dedupe_filter_with_pending_fifo.sv =====
// Top level of the address dedupe filter with pending FIFO.
//
//   channel   handshake          ports
//   command   start, busy        mode addr_bits addr_well_formed addr_kind signal_level
//                                seen_time_ms maker_id
//   result    done (one cycle)   status out_addr out_kind out_level out_time_ms out_maker
//                                queue_depth drop_total unique_total dup_total
//
// A word is taken when start is high and busy is low; busy stays high until the result
// is committed, and done is high for one cycle as busy falls. The receiver cannot stall.
// An observation searches the n recorded addresses (n up to 64) one after another,
// since the table memory yields one entry per cycle; pops, malformed words and an
// empty table skip the search. A new word may start while done is high.
// Reset clears control state and counters; the table and FIFO memories need no clearing.
`default_nettype none

module dedupe_filter_with_pending_fifo (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic                               mode,
	input  wire logic [ddf_pkg::ADDR_W-1:0]         addr_bits,
	input  wire logic                               addr_well_formed,
	input  wire logic [ddf_pkg::KIND_W-1:0]         addr_kind,
	input  wire logic signed [ddf_pkg::LEVEL_W-1:0] signal_level,
	input  wire logic [ddf_pkg::TIME_W-1:0]         seen_time_ms,
	input  wire logic [ddf_pkg::MAKER_W-1:0]        maker_id,
	output logic                                    done,
	output logic [2:0]                              status,
	output logic [ddf_pkg::ADDR_W-1:0]              out_addr,
	output logic [ddf_pkg::KIND_W-1:0]              out_kind,
	output logic signed [ddf_pkg::LEVEL_W-1:0]      out_level,
	output logic [ddf_pkg::TIME_W-1:0]              out_time_ms,
	output logic [ddf_pkg::MAKER_W-1:0]             out_maker,
	output logic [ddf_pkg::DEPTH_W-1:0]             queue_depth,
	output logic [ddf_pkg::TOTAL_W-1:0]             drop_total,
	output logic [ddf_pkg::TOTAL_W-1:0]             unique_total,
	output logic [ddf_pkg::TOTAL_W-1:0]             dup_total
);

	ddf_pkg::cmd_t    cmd;
	ddf_pkg::sts_t    sts;
	ddf_pkg::status_t status_e;

	ddf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	ddf_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.mode             (mode),
		.addr_bits        (addr_bits),
		.addr_well_formed (addr_well_formed),
		.addr_kind        (addr_kind),
		.signal_level     (signal_level),
		.seen_time_ms     (seen_time_ms),
		.maker_id         (maker_id),
		.done             (done),
		.status           (status_e),
		.out_addr         (out_addr),
		.out_kind         (out_kind),
		.out_level        (out_level),
		.out_time_ms      (out_time_ms),
		.out_maker        (out_maker),
		.queue_depth      (queue_depth),
		.drop_total       (drop_total),
		.unique_total     (unique_total),
		.dup_total        (dup_total)
	);

	assign status = status_e;

	// A result is only shown once the controller has returned to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not make the block busy");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> queue_depth <= ddf_pkg::DEPTH_W'(ddf_pkg::QUEUE_DEPTH))
		else $error("queue depth above FIFO size");

	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ddf_pkg::ST_POPPED |-> out_addr == '0 && out_kind == '0
			&& out_level == '0 && out_time_ms == '0 && out_maker == '0)
		else $error("entry payload on a result that is not a pop");

endmodule

`default_nettype wire
